[sv/ksat_pkg.sv]
// Package for the keyed sales aggregation table: sizes, op and status codes, states.
// No dependencies.
package ksat_pkg;
  localparam int PSLOTS = 256;
  localparam int CSLOTS = 64;
  localparam int PAW = $clog2(PSLOTS);
  localparam int CAW = $clog2(CSLOTS);
  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;
  localparam logic [55:0] AMAX = 56'hFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_ORDER = 2'd1, OP_RDPROD = 2'd2, OP_RDCUST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_PFULL = 3'd1, ST_CFULL = 3'd2, ST_UNUSED = 3'd3, ST_ZERO = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PSCAN, S_PUPD, S_MUL, S_PWR, S_CSCAN, S_RDP, S_RDC, S_DONE
  } state_t;
endpackage

[sv/keyed_sales_aggregation_table_unit.sv]
// Keyed sales aggregation table: product and customer tables in RAM, sequential scan.
// Depends on ksat_pkg.
//
// One request at a time; busy stays high until its result strobe. After reset a clearing
// pass wipes the product RAM and customer sums (busy high). An order scans the product
// slots in turn up to the match or an empty slot, multiplies and writes back the product
// entry, then scans the loaded customers and adds to each match; reads go through the
// single read port of each table RAM. The receiver cannot stall: each result appears
// for one cycle with done high.
module keyed_sales_aggregation_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [19:0] product_code,
  input  logic [26:0] customer_id,
  input  logic [23:0] quantity,
  input  logic [23:0] unit_price,
  input  logic [7:0]  entry_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  slot,
  output logic        new_entry,
  output logic [6:0]  match_count,
  output logic [8:0]  product_count,
  output logic [6:0]  customer_count,
  output logic [26:0] entry_key,
  output logic [23:0] entry_price,
  output logic [31:0] entry_quantity,
  output logic [55:0] entry_amount
);
  import ksat_pkg::*;

  logic [131:0] pmem [PSLOTS];
  logic [82:0]  cmem [CSLOTS];

  state_t state, state_next;
  logic [PAW:0] pidx;
  logic [CAW:0] cidx;
  logic [8:0]   pused;
  logic [CAW:0] cused;
  logic [19:0]  r_code;
  logic [26:0]  r_cid;
  logic [23:0]  r_qty, r_price;
  logic [7:0]   r_idx;
  logic [47:0]  sub;
  logic [131:0] prd, pwd;
  logic [82:0]  crd;
  logic         pwe, cwe, rdv;
  logic [PAW-1:0] pwa, pra;
  logic [CAW-1:0] cwa, cra;
  logic [82:0]  cwd;
  logic [CAW-1:0] cprev;
  logic         cprev_v;
  logic [6:0]   hits;
  logic [56:0]  asum;

  logic [19:0] pcode;
  logic [23:0] pprice;
  logic [31:0] pq;
  logic [55:0] pamt;
  assign pcode  = prd[131:112];
  assign pprice = prd[111:88];
  assign pq     = prd[87:56];
  assign pamt   = prd[55:0];

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    prd <= pmem[pra];
    if (cwe) cmem[cwa] <= cwd;
    crd <= cmem[cra];
  end

  logic [32:0] qsum;
  logic [56:0] psum;
  assign qsum = {1'b0, pq} + {9'd0, r_qty};
  assign psum = {1'b0, pamt} + {9'd0, sub};
  assign asum = {1'b0, crd[55:0]} + {9'd0, sub};

  always_comb begin
    state_next = state;
    pwe = 1'b0;
    pwa = pidx[PAW-1:0];
    pwd = '0;
    pra = pidx[PAW-1:0];
    cwe = 1'b0;
    cwa = cidx[CAW-1:0];
    cwd = '0;
    cra = cidx[CAW-1:0];
    case (state)
      S_CLEAR: begin
        pwe = 1'b1;
        cwe = (pidx < (PAW+1)'(CSLOTS));
        cwa = pidx[CAW-1:0];
        if (pidx == (PAW+1)'(PSLOTS-1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        pra = '0;
        if (start) begin
          case (op_t'(op))
            OP_LOAD: state_next = S_DONE;
            OP_ORDER: state_next = (product_code == '0) ? S_DONE : S_PSCAN;
            OP_RDPROD: begin
              pra = entry_index[PAW-1:0];
              state_next = S_RDP;
            end
            default: begin
              cra = entry_index[CAW-1:0];
              state_next = S_RDC;
            end
          endcase
        end
        if (start && op_t'(op) == OP_LOAD && cused < (CAW+1)'(CSLOTS)) begin
          cwe = 1'b1;
          cwa = cused[CAW-1:0];
          cwd = {customer_id, 56'd0};
        end
      end
      S_PSCAN: begin
        pra = pidx[PAW-1:0];
        if (rdv) begin
          if (pcode == r_code || pcode == '0) state_next = S_MUL;
          else if (pidx == (PAW+1)'(PSLOTS-1)) state_next = S_DONE;
        end
      end
      S_MUL: begin
        pra = pidx[PAW-1:0];
        state_next = S_PWR;
      end
      S_PWR: begin
        pwe = 1'b1;
        pwd = {r_code, r_price, qsum[32] ? QMAX : qsum[31:0], psum[56] ? AMAX : psum[55:0]};
        cra = '0;
        state_next = S_CSCAN;
      end
      S_CSCAN: begin
        cra = cidx[CAW-1:0];
        if (cprev_v && crd[82:56] == r_cid) begin
          cwe = 1'b1;
          cwa = cprev;
          cwd = {crd[82:56], asum[56] ? AMAX : asum[55:0]};
        end
        if (cidx >= cused) state_next = S_DONE;
      end
      S_RDP: state_next = S_DONE;
      S_RDC: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pidx <= '0;
      cidx <= '0;
      pused <= '0;
      cused <= '0;
      done <= 1'b0;
      rdv <= 1'b0;
      cprev_v <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      rdv <= 1'b0;
      cprev_v <= 1'b0;
      case (state)
        S_CLEAR: pidx <= pidx + 1'b1;
        S_IDLE: if (start) begin
          r_code <= product_code; r_cid <= customer_id;
          r_qty <= quantity; r_price <= unit_price; r_idx <= entry_index;
          pidx <= '0; cidx <= '0; hits <= '0;
          rdv <= 1'b1;
          status <= ST_OK; slot <= '0; new_entry <= 1'b0; match_count <= '0;
          entry_key <= '0; entry_price <= '0; entry_quantity <= '0; entry_amount <= '0;
          case (op_t'(op))
            OP_LOAD: if (cused < (CAW+1)'(CSLOTS)) begin
              slot <= 8'(cused);
              cused <= cused + 1'b1;
            end else status <= ST_CFULL;
            OP_ORDER: if (product_code == '0) status <= ST_ZERO;
            OP_RDPROD: slot <= entry_index;
            default: slot <= entry_index;
          endcase
        end
        S_PSCAN: if (rdv) begin
          if (pcode == r_code || pcode == '0) begin
            slot <= 8'(pidx);
            if (pcode == '0) begin
              new_entry <= 1'b1;
              pused <= pused + 1'b1;
            end
          end else if (pidx == (PAW+1)'(PSLOTS-1)) status <= ST_PFULL;
          else begin
            pidx <= pidx + 1'b1;
          end
        end else rdv <= 1'b1;
        S_MUL: sub <= r_qty * r_price;
        S_CSCAN: begin
          if (cprev_v && crd[82:56] == r_cid) hits <= hits + 1'b1;
          cprev <= cidx[CAW-1:0];
          cprev_v <= (cidx < cused);
          cidx <= cidx + 1'b1;
          if (cidx >= cused) match_count <= hits +
            7'(cprev_v && crd[82:56] == r_cid);
        end
        S_RDP: if (r_idx >= 8'(PSLOTS-1) + 8'd1 && PSLOTS < 256 || pcode == '0)
          status <= ST_UNUSED;
        else begin
          entry_key <= 27'(pcode); entry_price <= pprice;
          entry_quantity <= pq; entry_amount <= pamt;
        end
        S_RDC: if ({1'b0, r_idx} >= 9'(cused)) status <= ST_UNUSED;
        else begin
          entry_key <= crd[82:56]; entry_amount <= crd[55:0];
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign product_count = pused;
  assign customer_count = 7'(cused);

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_pused: assert property (@(posedge clk) disable iff (rst) pused <= 9'(PSLOTS))
    else $error("product count overflow");
  a_cused: assert property (@(posedge clk) disable iff (rst) cused <= (CAW+1)'(CSLOTS))
    else $error("customer count overflow");
endmodule

[tb/sv/keyed_sales_aggregation_table_unit_tb.sv]
// Testbench for keyed_sales_aggregation_table_unit: random and directed requests, scoreboard check.
// Depends on ksat_pkg and the block; the scoreboard predicts every result from accepted requests.
`timescale 1ns / 100ps

module keyed_sales_aggregation_table_unit_tb;
  import ksat_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        new_entry;
    logic [6:0]  match_count;
    logic [8:0]  product_count;
    logic [6:0]  customer_count;
    logic [26:0] entry_key;
    logic [23:0] entry_price;
    logic [31:0] entry_quantity;
    logic [55:0] entry_amount;
  } sale_res_t;

  class sales_scoreboard;
    logic [19:0] codes[PSLOTS];
    logic [23:0] prices[PSLOTS];
    logic [31:0] qty_sum[PSLOTS];
    logic [55:0] amt_sum[PSLOTS];
    logic [26:0] cust_id[CSLOTS];
    logic [55:0] cust_spent[CSLOTS];
    int          used;
    int          loaded;
    sale_res_t   pending[$];
    int          errors;
    int          requests;
    int          results;
    int          full_hits;

    function new();
      for (int i = 0; i < PSLOTS; i++) begin
        codes[i] = '0;
        prices[i] = '0;
        qty_sum[i] = '0;
        amt_sum[i] = '0;
      end
      for (int i = 0; i < CSLOTS; i++) begin
        cust_id[i] = '0;
        cust_spent[i] = '0;
      end
      used = 0;
      loaded = 0;
      errors = 0;
      requests = 0;
      results = 0;
      full_hits = 0;
    endfunction

    function logic [55:0] add_amount(logic [55:0] a, logic [47:0] b);
      logic [56:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[56] ? AMAX : s[55:0];
    endfunction

    function void note(logic [1:0] o, logic [19:0] code, logic [26:0] cid, logic [23:0] qty,
                       logic [23:0] price, logic [7:0] idx);
      sale_res_t r;
      logic [47:0] sub;
      logic [32:0] qs;
      int s;
      int hits;
      r = '0;
      s = -1;
      hits = 0;
      requests++;
      case (o)
        OP_LOAD: begin
          if (loaded >= CSLOTS) begin
            r.status = ST_CFULL;
            full_hits++;
          end else begin
            cust_id[loaded] = cid;
            cust_spent[loaded] = '0;
            r.slot = loaded[7:0];
            loaded++;
          end
        end
        OP_ORDER: begin
          if (code == 0) begin
            r.status = ST_ZERO;
          end else begin
            for (int i = 0; i < PSLOTS; i++)
              if (s < 0 && (codes[i] == code || codes[i] == 0)) s = i;
            if (s < 0) begin
              r.status = ST_PFULL;
              full_hits++;
            end else begin
              sub = qty * price;
              if (codes[s] == 0) begin
                used++;
                r.new_entry = 1'b1;
              end
              codes[s] = code;
              prices[s] = price;
              qs = {1'b0, qty_sum[s]} + {9'd0, qty};
              qty_sum[s] = qs[32] ? QMAX : qs[31:0];
              amt_sum[s] = add_amount(amt_sum[s], sub);
              for (int i = 0; i < loaded; i++)
                if (cust_id[i] == cid) begin
                  cust_spent[i] = add_amount(cust_spent[i], sub);
                  hits++;
                end
              r.slot = s[7:0];
              r.match_count = hits[6:0];
            end
          end
        end
        OP_RDPROD: begin
          r.slot = idx;
          if (codes[idx] == 0) begin
            r.status = ST_UNUSED;
          end else begin
            r.entry_key = {7'd0, codes[idx]};
            r.entry_price = prices[idx];
            r.entry_quantity = qty_sum[idx];
            r.entry_amount = amt_sum[idx];
          end
        end
        default: begin
          r.slot = idx;
          if (idx >= loaded) begin
            r.status = ST_UNUSED;
          end else begin
            r.entry_key = cust_id[idx];
            r.entry_amount = cust_spent[idx];
          end
        end
      endcase
      r.product_count = used[8:0];
      r.customer_count = loaded[6:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task check(sale_res_t got);
      sale_res_t w;
      results++;
      if (pending.size() == 0) begin
        report("result with no request", 0, 0);
      end else begin
        w = pending.pop_front();
        if (got.status != w.status) report("status", got.status, w.status);
        if (got.slot != w.slot) report("slot", got.slot, w.slot);
        if (got.new_entry != w.new_entry) report("new_entry", got.new_entry, w.new_entry);
        if (got.match_count != w.match_count)
          report("match_count", got.match_count, w.match_count);
        if (got.product_count != w.product_count)
          report("product_count", got.product_count, w.product_count);
        if (got.customer_count != w.customer_count)
          report("customer_count", got.customer_count, w.customer_count);
        if (got.entry_key != w.entry_key) report("entry_key", got.entry_key, w.entry_key);
        if (got.entry_price != w.entry_price)
          report("entry_price", got.entry_price, w.entry_price);
        if (got.entry_quantity != w.entry_quantity)
          report("entry_quantity", got.entry_quantity, w.entry_quantity);
        if (got.entry_amount != w.entry_amount)
          report("entry_amount", got.entry_amount, w.entry_amount);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [19:0] product_code;
  logic [26:0] customer_id;
  logic [23:0] quantity;
  logic [23:0] unit_price;
  logic [7:0]  entry_index;
  logic        done;
  sale_res_t   res;

  sales_scoreboard sb;

  keyed_sales_aggregation_table_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .product_code(product_code), .customer_id(customer_id),
    .quantity(quantity), .unit_price(unit_price), .entry_index(entry_index),
    .done(done), .status(res.status), .slot(res.slot), .new_entry(res.new_entry),
    .match_count(res.match_count), .product_count(res.product_count),
    .customer_count(res.customer_count), .entry_key(res.entry_key),
    .entry_price(res.entry_price), .entry_quantity(res.entry_quantity),
    .entry_amount(res.entry_amount)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check(res);
      if (start && !busy)
        sb.note(op, product_code, customer_id, quantity, unit_price, entry_index);
    end
  end

  task issue(logic [1:0] o, logic [19:0] code, logic [26:0] cid, logic [23:0] qty,
             logic [23:0] price, logic [7:0] idx, int gap_pct);
    start <= 1'b1;
    op <= o;
    product_code <= code;
    customer_id <= cid;
    quantity <= qty;
    unit_price <= price;
    entry_index <= idx;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [26:0] pick_cid();
    case ($urandom_range(9))
      0: return 27'd0;
      1: return 27'h7FF_FFFF;
      2: return 27'd99999999;
      3, 4: return 27'd12345;
      5: return 27'd777;
      6: return 27'd42;
      default: return 27'($urandom);
    endcase
  endfunction

  function logic [23:0] pick_amount();
    case ($urandom_range(9))
      0, 1, 2: return 24'hFF_FFFF;
      3: return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  task random_item(int gap_pct);
    logic [19:0] code;
    int pick;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0, 1: code = 20'($urandom_range(12, 1));
      2: code = 20'($urandom);
      default: code = (pick < 50) ? 20'($urandom_range(12, 1)) :
                                    20'($urandom_range(999999, 1));
    endcase
    if (pick < 10)
      issue(OP_LOAD, 20'($urandom), pick_cid(), 24'($urandom), 24'($urandom),
            8'($urandom), gap_pct);
    else if (pick < 70)
      issue(OP_ORDER, code, pick_cid(), pick_amount(), pick_amount(), 8'($urandom),
            gap_pct);
    else if (pick < 85)
      issue(OP_RDPROD, 20'($urandom), 27'($urandom), 24'($urandom), 24'($urandom),
            8'($urandom), gap_pct);
    else
      issue(OP_RDCUST, 20'($urandom), 27'($urandom), 24'($urandom), 24'($urandom),
            ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(CSLOTS - 1)),
            gap_pct);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    op = OP_LOAD;
    product_code = '0;
    customer_id = '0;
    quantity = '0;
    unit_price = '0;
    entry_index = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue(OP_RDPROD, 0, 0, 0, 0, 8'd0, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'd0, 0);
    issue(OP_ORDER, 20'd0, 27'd42, 24'd100, 24'd100, 0, 0);
    issue(OP_LOAD, 0, 27'd0, 0, 0, 0, 0);
    issue(OP_LOAD, 0, 27'h7FF_FFFF, 0, 0, 0, 0);
    issue(OP_LOAD, 0, 27'd99999999, 0, 0, 0, 0);
    issue(OP_LOAD, 0, 27'd0, 0, 0, 0, 0);
    issue(OP_ORDER, 20'd1, 27'd0, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0);
    issue(OP_ORDER, 20'hF_FFFF, 27'h7FF_FFFF, 24'd0, 24'd0, 0, 0);
    issue(OP_ORDER, 20'd999999, 27'd99999999, 24'd256, 24'd512, 8'hFF, 0);
    issue(OP_ORDER, 20'd1, 27'd5, 24'd1, 24'd3, 0, 0);
    issue(OP_RDPROD, 0, 0, 0, 0, 8'd0, 0);
    issue(OP_RDPROD, 0, 0, 0, 0, 8'd1, 0);
    issue(OP_RDPROD, 0, 0, 0, 0, 8'd2, 0);
    issue(OP_RDPROD, 0, 0, 0, 0, 8'hFF, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'd0, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'd3, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'd4, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'hFF, 0);
    drain();

    repeat (600) random_item(30);
    drain();
    repeat (600) random_item(82);
    drain();
    repeat (270) issue(OP_ORDER, 20'd1, 27'd0, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0);
    repeat (400) random_item(0);
    issue(OP_RDPROD, 0, 0, 0, 0, 8'd0, 0);
    issue(OP_RDCUST, 0, 0, 0, 0, 8'd0, 0);
    drain();
    repeat (20) @(posedge clk);

    $display("run: %0d requests, %0d results, %0d table-full results, %0d products used",
             sb.requests, sb.results, sb.full_hits, sb.used);
    $display("covered loads, orders up to saturation, reads of used and unused slots");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

[files.f]
sv/ksat_pkg.sv
sv/keyed_sales_aggregation_table_unit.sv
tb/sv/keyed_sales_aggregation_table_unit_tb.sv
